// File: rtl/cda_pkg.sv
package cda_pkg;

    localparam int PIPE_DEPTH = 14;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_UTC   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // reciprocals, each exact (or off by one low) over the value range it sees
    localparam logic [18:0] RECIP_12     = 19'd349526;
    localparam logic [16:0] RECIP_25     = 17'd83887;
    localparam logic [17:0] RECIP_100    = 18'd167773;
    localparam logic [10:0] RECIP_146097 = 11'd1837;
    localparam logic [7:0]  RECIP_1461   = 8'd179;
    localparam logic [11:0] RECIP_153    = 12'd3427;

    localparam logic [17:0] DAYS_400Y = 18'd146097;
    localparam logic [10:0] DAYS_4Y   = 11'd1461;

    // year bias of 4800 plus 100 eras of 400 years, keeps every floor positive
    localparam logic signed [17:0] YEAR_BIAS    = 18'sd44800;
    localparam logic signed [25:0] JDN_BIAS     = 26'sd14641745;
    localparam logic [25:0]        ERA_DAY_BIAS = 26'd14641744;
    localparam logic [13:0]        YEAR_MAX     = 14'd9999;

    typedef struct packed {
        logic        pad;
        logic [22:0] day_offset;
        logic [17:0] month_offset;
        logic [14:0] year_offset;
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  status;
        logic [8:0]  year_length;
        logic [4:0]  month_length;
        logic [22:0] day_number;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
    } out_word_t;

    // days before the month, counted from march (index 0) to february (index 11)
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] days;
        unique case (idx)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] days;
        unique case (mon)
            4'd2:                      days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

// File: rtl/calendar_date_add.sv
// calendar_date_add: gregorian date plus signed year, month and day offsets.
// s_axis carries one request word: start date, the three offsets, and in
// tuser the utc flag (utc requests are answered with status 1 and zeros).
// m_axis carries one result word per request: new date, its julian day
// number, days in its month and year, and a status (0 ok, 1 utc,
// 2 invalid start or result year outside 1..9999, other fields zero).
// The block is a 14-register pipeline, stages 0 to 13, from s_axis to
// m_axis. It takes one word per cycle when nothing stalls; every stage
// holds one multiply by a reciprocal or a few adds, the longest being the
// 28 by 11 bit quotient estimate for the 400-year era.
// Each stage has its own valid bit and only moves when the stage after it is
// empty or moving, so bubbles close up and input keeps flowing while a
// result waits in the output register. When m_axis_tready stays low the
// pipeline fills and s_axis_tready falls once all stages hold a word.
// Reset clears the valid bits only; no result is pending after reset and
// the first request may be sent on the first cycle after it.
module calendar_date_add
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_year[13:0] start_month[17:14] start_day[22:18] year_offset[37:23]
    // month_offset[55:38] day_offset[78:56] zero[79]
    input  logic [79:0] s_axis_tdata,
    // is_utc[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_year[13:0] new_month[17:14] new_day[22:18] day_number[45:23]
    // month_length[50:46] year_length[59:51] status[61:60] zero[63:62]
    output logic [63:0] m_axis_tdata
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] load;

    // stage 0: input register
    in_word_t s0_word_reg;
    logic     s0_utc_reg;

    // stage 1: month offset quotient estimate
    logic [17:0] s1_mabs_next;
    logic [36:0] s1_q12_prod;
    logic [1:0]  s1_status_next;
    logic [13:0] s1_year_reg;
    logic [3:0]  s1_mon_reg;
    logic [4:0]  s1_day_reg;
    logic [14:0] s1_yoff_reg;
    logic [17:0] s1_mabs_reg;
    logic        s1_neg_reg;
    logic [13:0] s1_q12_reg;
    logic [22:0] s1_doff_reg;
    logic        s1_hasoff_reg;
    logic [1:0]  s1_status_reg;

    // stage 2: month wrap and year sum
    logic [17:0]        s2_rem_full;
    logic signed [14:0] s2_quo;
    logic signed [5:0]  s2_rem_s;
    logic signed [5:0]  s2_m0;
    logic signed [5:0]  s2_mw;
    logic signed [16:0] s2_ysum;
    logic signed [16:0] s2_yw;
    logic signed [16:0] s2_year_next;
    logic [3:0]         s2_mon_next;
    logic signed [16:0] s2_year_reg;
    logic [3:0]         s2_mon_reg;
    logic [4:0]         s2_day_reg;
    logic [22:0]        s2_doff_reg;
    logic               s2_hasoff_reg;
    logic [1:0]         s2_status_reg;

    // stage 3: year divided by 25
    logic [16:0]        s3_ytmp;
    logic [32:0]        s3_q25_prod;
    logic [15:0]        s3_yabs_reg;
    logic [11:0]        s3_q25_reg;
    logic signed [16:0] s3_year_reg;
    logic [3:0]         s3_mon_reg;
    logic [4:0]         s3_day_reg;
    logic [22:0]        s3_doff_reg;
    logic               s3_hasoff_reg;
    logic [1:0]         s3_status_reg;

    // stage 4: leap year, clamp, shifted year
    logic               s4_d25;
    logic               s4_leap;
    logic [4:0]         s4_mlen;
    logic               s4_early;
    logic signed [17:0] s4_yyp_full;
    logic [4:0]         s4_day_next;
    logic signed [23:0] s4_doff_next;
    logic [16:0]        s4_yyp_reg;
    logic [3:0]         s4_mi_reg;
    logic [4:0]         s4_day_reg;
    logic signed [23:0] s4_doff_reg;
    logic [1:0]         s4_status_reg;

    // stage 5: century quotient, 365 times year, partial day sum
    logic [34:0]        s5_q100_prod;
    logic [24:0]        s5_t365_next;
    logic signed [25:0] s5_part_next;
    logic [10:0]        s5_q100_reg;
    logic [24:0]        s5_t365_reg;
    logic signed [25:0] s5_part_reg;
    logic [1:0]         s5_status_reg;

    // stage 6: day number
    logic signed [25:0] s6_jd_next;
    logic signed [25:0] s6_jd_reg;
    logic [1:0]         s6_status_reg;

    // stage 7: era quotient estimate
    logic [25:0] s7_ap;
    logic [27:0] s7_n_next;
    logic [38:0] s7_q_prod;
    logic [27:0] s7_n_reg;
    logic [10:0] s7_q_reg;
    logic [22:0] s7_jd_reg;
    logic [1:0]  s7_status_reg;

    // stage 8: era correction, day of era
    logic [27:0] s8_r;
    logic [27:0] s8_rc;
    logic [10:0] s8_b_next;
    logic [10:0] s8_b_reg;
    logic [15:0] s8_c_reg;
    logic [22:0] s8_jd_reg;
    logic [1:0]  s8_status_reg;

    // stage 9: four-year cycle quotient estimate
    logic [17:0] s9_n_next;
    logic [25:0] s9_q_prod;
    logic [17:0] s9_n_reg;
    logic [7:0]  s9_q_reg;
    logic [10:0] s9_b_reg;
    logic [22:0] s9_jd_reg;
    logic [1:0]  s9_status_reg;

    // stage 10: four-year correction, day of year, base year
    logic [17:0]        s10_r;
    logic [17:0]        s10_rc;
    logic [7:0]         s10_e4;
    logic signed [17:0] s10_ybase_next;
    logic [8:0]         s10_e_reg;
    logic signed [17:0] s10_ybase_reg;
    logic [22:0]        s10_jd_reg;
    logic [1:0]         s10_status_reg;

    // stage 11: month index from day of year
    logic [10:0]        s11_num;
    logic [22:0]        s11_f_prod;
    logic [3:0]         s11_f_reg;
    logic [8:0]         s11_e_reg;
    logic signed [17:0] s11_ybase_reg;
    logic [22:0]        s11_jd_reg;
    logic [1:0]         s11_status_reg;

    // stage 12: calendar fields, result year divided by 25
    logic               s12_late;
    logic [8:0]         s12_d9;
    logic signed [17:0] s12_y_next;
    logic [30:0]        s12_q25_prod;
    logic signed [17:0] s12_y_reg;
    logic [3:0]         s12_m_reg;
    logic [4:0]         s12_d_reg;
    logic [9:0]         s12_q25_reg;
    logic [22:0]        s12_jd_reg;
    logic [1:0]         s12_status_reg;

    // stage 13: output register
    logic [13:0] s13_y14;
    logic        s13_d25;
    logic        s13_leap;
    logic        s13_in_range;
    out_word_t   out_next;
    out_word_t   out_reg;

    // flow control
    always_comb
    begin
        load[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_axis_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign s_axis_tready = load[0];
    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 0
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_word_reg <= in_word_t'(s_axis_tdata);
            s0_utc_reg  <= s_axis_tuser;
        end
    end

    // stage 1
    always_comb
    begin
        s1_mabs_next = s0_word_reg.month_offset[17] ? (18'd0 - s0_word_reg.month_offset)
                                                    : s0_word_reg.month_offset;
        s1_q12_prod  = 37'(s1_mabs_next) * 37'(RECIP_12);
        if (s0_utc_reg)
        begin
            s1_status_next = STATUS_UTC;
        end
        else if (s0_word_reg.start_month == 4'd0 || s0_word_reg.start_month > 4'd12
                 || s0_word_reg.start_day == 5'd0)
        begin
            s1_status_next = STATUS_RANGE;
        end
        else
        begin
            s1_status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s1_year_reg   <= s0_word_reg.start_year;
            s1_mon_reg    <= s0_word_reg.start_month;
            s1_day_reg    <= s0_word_reg.start_day;
            s1_yoff_reg   <= s0_word_reg.year_offset;
            s1_mabs_reg   <= s1_mabs_next;
            s1_neg_reg    <= s0_word_reg.month_offset[17];
            s1_q12_reg    <= s1_q12_prod[35:22];
            s1_doff_reg   <= s0_word_reg.day_offset;
            s1_hasoff_reg <= (s0_word_reg.year_offset != 15'd0)
                          || (s0_word_reg.month_offset != 18'd0);
            s1_status_reg <= s1_status_next;
        end
    end

    // stage 2: truncating quotient and remainder, as the offset sign dictates
    always_comb
    begin
        s2_rem_full = s1_mabs_reg - ({4'd0, s1_q12_reg} * 18'd12);
        s2_quo      = s1_neg_reg ? -$signed({1'b0, s1_q12_reg}) : $signed({1'b0, s1_q12_reg});
        s2_rem_s    = s1_neg_reg ? -$signed({2'b00, s2_rem_full[3:0]})
                                 : $signed({2'b00, s2_rem_full[3:0]});
        s2_m0       = $signed({2'b00, s1_mon_reg}) - 6'sd1 + s2_rem_s;
        s2_ysum     = $signed({3'b000, s1_year_reg}) + 17'($signed(s1_yoff_reg))
                    + 17'(s2_quo);
        s2_yw       = s2_ysum;
        s2_mw       = s2_m0;
        if (s2_m0 > 6'sd11)
        begin
            s2_yw = s2_ysum + 17'sd1;
            s2_mw = s2_m0 - 6'sd12;
        end
        else if (s2_m0 < 6'sd0)
        begin
            s2_yw = s2_ysum - 17'sd1;
            s2_mw = s2_m0 + 6'sd12;
        end
        if (s1_hasoff_reg)
        begin
            s2_year_next = s2_yw;
            s2_mon_next  = s2_mw[3:0] + 4'd1;
        end
        else
        begin
            s2_year_next = $signed({3'b000, s1_year_reg});
            s2_mon_next  = s1_mon_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s2_year_reg   <= s2_year_next;
            s2_mon_reg    <= s2_mon_next;
            s2_day_reg    <= s1_day_reg;
            s2_doff_reg   <= s1_doff_reg;
            s2_hasoff_reg <= s1_hasoff_reg;
            s2_status_reg <= s1_status_reg;
        end
    end

    // stage 3
    always_comb
    begin
        s3_ytmp     = s2_year_reg[16] ? (17'd0 - 17'(s2_year_reg)) : 17'(s2_year_reg);
        s3_q25_prod = 33'(s3_ytmp[15:0]) * 33'(RECIP_25);
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s3_yabs_reg   <= s3_ytmp[15:0];
            s3_q25_reg    <= s3_q25_prod[32:21];
            s3_year_reg   <= s2_year_reg;
            s3_mon_reg    <= s2_mon_reg;
            s3_day_reg    <= s2_day_reg;
            s3_doff_reg   <= s2_doff_reg;
            s3_hasoff_reg <= s2_hasoff_reg;
            s3_status_reg <= s2_status_reg;
        end
    end

    // stage 4: a day past the new month end is clamped, the excess moves on
    always_comb
    begin
        s4_d25       = s3_yabs_reg == ({4'd0, s3_q25_reg} * 16'd25);
        s4_leap      = (s3_yabs_reg[1:0] == 2'd0 && !s4_d25)
                    || (s3_yabs_reg[3:0] == 4'd0 && s4_d25);
        s4_mlen      = month_days(s3_mon_reg, s4_leap);
        s4_early     = s3_mon_reg <= 4'd2;
        s4_yyp_full  = 18'(s3_year_reg) + YEAR_BIAS - (s4_early ? 18'sd1 : 18'sd0);
        s4_day_next  = s3_day_reg;
        s4_doff_next = 24'($signed(s3_doff_reg));
        if (s3_hasoff_reg && s3_day_reg > s4_mlen)
        begin
            s4_day_next  = s4_mlen;
            s4_doff_next = 24'($signed(s3_doff_reg)) + $signed({19'd0, s3_day_reg - s4_mlen});
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s4_yyp_reg    <= s4_yyp_full[16:0];
            s4_mi_reg     <= s4_early ? (s3_mon_reg + 4'd9) : (s3_mon_reg - 4'd3);
            s4_day_reg    <= s4_day_next;
            s4_doff_reg   <= s4_doff_next;
            s4_status_reg <= s3_status_reg;
        end
    end

    // stage 5
    always_comb
    begin
        s5_q100_prod = 35'(s4_yyp_reg) * 35'(RECIP_100);
        s5_t365_next = 25'(s4_yyp_reg) * 25'd365;
        s5_part_next = $signed(26'(s4_day_reg)) + $signed(26'(month_start(s4_mi_reg)))
                     + $signed(26'(s4_yyp_reg[16:2])) + 26'(s4_doff_reg) - JDN_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s5_q100_reg   <= s5_q100_prod[34:24];
            s5_t365_reg   <= s5_t365_next;
            s5_part_reg   <= s5_part_next;
            s5_status_reg <= s4_status_reg;
        end
    end

    // stage 6
    assign s6_jd_next = s5_part_reg + $signed(26'(s5_t365_reg)) - $signed(26'(s5_q100_reg))
                      + $signed(26'(s5_q100_reg[10:2]));

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s6_jd_reg     <= s6_jd_next;
            s6_status_reg <= s5_status_reg;
        end
    end

    // stage 7
    always_comb
    begin
        s7_ap     = 26'(s6_jd_reg) + ERA_DAY_BIAS;
        s7_n_next = {s7_ap, 2'b11};
        s7_q_prod = 39'(s7_n_next) * 39'(RECIP_146097);
    end

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            s7_n_reg      <= s7_n_next;
            s7_q_reg      <= s7_q_prod[38:28];
            s7_jd_reg     <= s6_jd_reg[22:0];
            s7_status_reg <= s6_status_reg;
        end
    end

    // stage 8: estimate is exact or one low
    always_comb
    begin
        s8_r      = s7_n_reg - (28'(s7_q_reg) * 28'(DAYS_400Y));
        s8_rc     = s8_r;
        s8_b_next = s7_q_reg;
        if (s8_r >= 28'(DAYS_400Y))
        begin
            s8_rc     = s8_r - 28'(DAYS_400Y);
            s8_b_next = s7_q_reg + 11'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[8])
        begin
            s8_b_reg      <= s8_b_next;
            s8_c_reg      <= s8_rc[17:2];
            s8_jd_reg     <= s7_jd_reg;
            s8_status_reg <= s7_status_reg;
        end
    end

    // stage 9
    always_comb
    begin
        s9_n_next = {s8_c_reg, 2'b11};
        s9_q_prod = 26'(s9_n_next) * 26'(RECIP_1461);
    end

    always_ff @(posedge clk)
    begin
        if (load[9])
        begin
            s9_n_reg      <= s9_n_next;
            s9_q_reg      <= s9_q_prod[25:18];
            s9_b_reg      <= s8_b_reg;
            s9_jd_reg     <= s8_jd_reg;
            s9_status_reg <= s8_status_reg;
        end
    end

    // stage 10
    always_comb
    begin
        s10_r  = s9_n_reg - (18'(s9_q_reg) * 18'(DAYS_4Y));
        s10_rc = s10_r;
        s10_e4 = s9_q_reg;
        if (s10_r >= 18'(DAYS_4Y))
        begin
            s10_rc = s10_r - 18'(DAYS_4Y);
            s10_e4 = s9_q_reg + 8'd1;
        end
        s10_ybase_next = $signed(18'(s9_b_reg) * 18'd100) + $signed(18'(s10_e4)) - YEAR_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (load[10])
        begin
            s10_e_reg      <= s10_rc[10:2];
            s10_ybase_reg  <= s10_ybase_next;
            s10_jd_reg     <= s9_jd_reg;
            s10_status_reg <= s9_status_reg;
        end
    end

    // stage 11
    always_comb
    begin
        s11_num    = (11'(s10_e_reg) * 11'd5) + 11'd2;
        s11_f_prod = 23'(s11_num) * 23'(RECIP_153);
    end

    always_ff @(posedge clk)
    begin
        if (load[11])
        begin
            s11_f_reg      <= s11_f_prod[22:19];
            s11_e_reg      <= s10_e_reg;
            s11_ybase_reg  <= s10_ybase_reg;
            s11_jd_reg     <= s10_jd_reg;
            s11_status_reg <= s10_status_reg;
        end
    end

    // stage 12: january and february belong to the next year
    always_comb
    begin
        s12_late     = s11_f_reg >= 4'd10;
        s12_d9       = s11_e_reg - month_start(s11_f_reg) + 9'd1;
        s12_y_next   = s11_ybase_reg + (s12_late ? 18'sd1 : 18'sd0);
        s12_q25_prod = 31'(s12_y_next[13:0]) * 31'(RECIP_25);
    end

    always_ff @(posedge clk)
    begin
        if (load[12])
        begin
            s12_y_reg      <= s12_y_next;
            s12_m_reg      <= s12_late ? (s11_f_reg - 4'd9) : (s11_f_reg + 4'd3);
            s12_d_reg      <= s12_d9[4:0];
            s12_q25_reg    <= s12_q25_prod[30:21];
            s12_jd_reg     <= s11_jd_reg;
            s12_status_reg <= s11_status_reg;
        end
    end

    // stage 13
    always_comb
    begin
        s13_y14      = s12_y_reg[13:0];
        s13_d25      = s13_y14 == ({4'd0, s12_q25_reg} * 14'd25);
        s13_leap     = (s13_y14[1:0] == 2'd0 && !s13_d25) || (s13_y14[3:0] == 4'd0 && s13_d25);
        s13_in_range = (s12_y_reg >= 18'sd1) && (s12_y_reg <= $signed(18'(YEAR_MAX)));
        out_next     = '0;
        if (s12_status_reg != STATUS_OK)
        begin
            out_next.status = s12_status_reg;
        end
        else if (!s13_in_range)
        begin
            out_next.status = STATUS_RANGE;
        end
        else
        begin
            out_next.new_year     = s13_y14;
            out_next.new_month    = s12_m_reg;
            out_next.new_day      = s12_d_reg;
            out_next.day_number   = s12_jd_reg;
            out_next.month_length = month_days(s12_m_reg, s13_leap);
            out_next.year_length  = s13_leap ? 9'd366 : 9'd365;
            out_next.status       = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[PIPE_DEPTH-1])
        begin
            out_reg <= out_next;
        end
    end

    // an empty output register lets the whole pipeline move
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[PIPE_DEPTH-1] |-> s_axis_tready)
        else $error("input stalled with output register empty");

    // input only backs up when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> ((&valid_reg) && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.status != STATUS_OK) |->
            (out_reg.new_year == 14'd0 && out_reg.new_month == 4'd0
             && out_reg.new_day == 5'd0 && out_reg.day_number == 23'd0
             && out_reg.month_length == 5'd0 && out_reg.year_length == 9'd0))
        else $error("failed result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.status == STATUS_OK) |->
            (out_reg.new_month >= 4'd1 && out_reg.new_month <= 4'd12
             && out_reg.new_day >= 5'd1 && out_reg.new_day <= out_reg.month_length
             && out_reg.new_year >= 14'd1 && out_reg.new_year <= YEAR_MAX))
        else $error("ok result is not a valid date");

endmodule

// File: dv/calendar_date_add_tb.sv
`timescale 1ns / 1ps

module calendar_date_add_tb
    import cda_pkg::*;
();

    localparam int RANDOM_ITEMS = 530;
    localparam int CYCLE_LIMIT  = 150000;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               utc;
        logic signed [14:0] yoff;
        logic signed [17:0] moff;
        logic signed [22:0] doff;
        bit                 drain;
    } date_req_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    date_req_t pending_dates[$];
    out_word_t expected_dates[$];
    date_req_t offered_date;
    date_req_t next_date;
    in_word_t  next_word;
    out_word_t want_date;
    out_word_t got_date;

    int  error_count  = 0;
    int  cycle_count  = 0;
    int  results_seen = 0;
    int  send_gap     = 0;
    int  recv_hold    = 0;
    bit  send_burst   = 1'b0;
    bit  recv_burst   = 1'b0;

    calendar_date_add uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor division, divisor always positive
    function automatic longint floor_div(input longint a, input longint b);
        return (a < 0) ? (a - (b - 1)) / b : a / b;
    endfunction

    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint days_in_month(input longint y, input longint m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic date_req_t make_req(input int year, input int month, input int day,
                                           input int utc, input int yoff, input int moff,
                                           input int doff);
        date_req_t r;
        r.year  = 14'(year);
        r.month = 4'(month);
        r.day   = 5'(day);
        r.utc   = 1'(utc);
        r.yoff  = 15'(yoff);
        r.moff  = 18'(moff);
        r.doff  = 23'(doff);
        r.drain = 1'b0;
        return r;
    endfunction

    function automatic out_word_t predict_date(input date_req_t r);
        out_word_t res;
        longint y, m, d, doff, mq, len, a, yy, mm, jd, b, c, e4, e, f, ny, nm, nd;
        res = '0;
        if (r.utc)
        begin
            res.status = STATUS_UTC;
            return res;
        end
        if (r.month < 1 || r.month > 12 || r.day == 0)
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        y    = r.year;
        m    = r.month;
        d    = r.day;
        doff = r.doff;

        // years and months first, day clamped with the excess carried forward
        if (r.yoff != 0 || r.moff != 0)
        begin
            mq = r.moff;
            m  = (m - 1) + mq % 12;
            y  = y + longint'(r.yoff) + mq / 12;
            if (m > 11)
            begin
                y = y + 1;
                m = m - 12;
            end
            else if (m < 0)
            begin
                y = y - 1;
                m = m + 12;
            end
            m   = m + 1;
            len = days_in_month(y, m);
            if (d > len)
            begin
                doff = doff + d - len;
                d    = len;
            end
        end

        a  = floor_div(14 - m, 12);
        yy = y + 4800 - a;
        mm = m + 12 * a - 3;
        jd = d + floor_div(153 * mm + 2, 5) + 365 * yy + floor_div(yy, 4)
           - floor_div(yy, 100) + floor_div(yy, 400) - 32045 + doff;

        a  = jd + 32044;
        b  = floor_div(4 * a + 3, 146097);
        c  = a - floor_div(146097 * b, 4);
        e4 = floor_div(4 * c + 3, 1461);
        e  = c - floor_div(1461 * e4, 4);
        f  = floor_div(5 * e + 2, 153);
        nd = e - floor_div(153 * f + 2, 5) + 1;
        nm = f + 3 - 12 * floor_div(f, 10);
        ny = 100 * b + e4 - 4800 + floor_div(f, 10);

        if (ny < 1 || ny > 9999)
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        res.new_year     = 14'(ny);
        res.new_month    = 4'(nm);
        res.new_day      = 5'(nd);
        res.day_number   = 23'(jd);
        res.month_length = 5'(days_in_month(ny, nm));
        res.year_length  = leap_year(ny) ? 9'd366 : 9'd365;
        res.status       = STATUS_OK;
        return res;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_dates.push_back(predict_date(offered_date));
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_dates.size() > 0 &&
                         !(pending_dates[0].drain && expected_dates.size() > 0))
                begin
                    next_date = pending_dates.pop_front();
                    next_word = '0;
                    next_word.start_year   = next_date.year;
                    next_word.start_month  = next_date.month;
                    next_word.start_day    = next_date.day;
                    next_word.year_offset  = next_date.yoff;
                    next_word.month_offset = next_date.moff;
                    next_word.day_offset   = next_date.doff;
                    s_axis_tdata  <= next_word;
                    s_axis_tuser  <= next_date.utc;
                    s_axis_tvalid <= 1'b1;
                    offered_date = next_date;
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    send_gap = draw_wait(send_burst);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_date = m_axis_tdata;
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want_date = expected_dates.pop_front();
                    check_field("new_year", want_date.new_year, got_date.new_year);
                    check_field("new_month", want_date.new_month, got_date.new_month);
                    check_field("new_day", want_date.new_day, got_date.new_day);
                    check_field("day_number", want_date.day_number, got_date.day_number);
                    check_field("month_length", want_date.month_length,
                                got_date.month_length);
                    check_field("year_length", want_date.year_length, got_date.year_length);
                    check_field("status", want_date.status, got_date.status);
                    check_field("pad", want_date.pad, got_date.pad);
                end
                results_seen++;
                // one long back-pressure stretch so the pipeline fills up
                if (results_seen == 200)
                    recv_hold = LONG_HOLD;
                else
                begin
                    if ($urandom_range(0, 39) == 0)
                        recv_burst = !recv_burst;
                    recv_hold = draw_wait(recv_burst);
                end
            end
            else if (recv_hold > 0)
                recv_hold--;
            m_axis_tready <= (recv_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int        i, kind, y, mo, dy, yo, mof, dof;
        date_req_t req;

        // clamp into leap and common february
        pending_dates.push_back(make_req(2024, 1, 31, 0, 0, 1, 0));
        pending_dates.push_back(make_req(2023, 1, 31, 0, 0, 1, 0));
        // day past month end with no year or month change rolls over
        pending_dates.push_back(make_req(2023, 2, 30, 0, 0, 0, 0));
        pending_dates.push_back(make_req(2024, 4, 31, 0, 0, 0, 0));
        // month wrap both ways
        pending_dates.push_back(make_req(2023, 3, 15, 0, 0, -5, 0));
        pending_dates.push_back(make_req(2023, 1, 10, 0, 0, -1, 0));
        pending_dates.push_back(make_req(2023, 11, 20, 0, 0, 3, 0));
        // utc start, also over an invalid month
        pending_dates.push_back(make_req(2023, 6, 15, 1, 0, 0, 0));
        pending_dates.push_back(make_req(2023, 0, 0, 1, 5, 5, 5));
        // invalid start
        pending_dates.push_back(make_req(2023, 0, 10, 0, 0, 0, 0));
        pending_dates.push_back(make_req(2023, 13, 10, 0, 0, 0, 0));
        pending_dates.push_back(make_req(2023, 15, 31, 0, 1, 0, 0));
        pending_dates.push_back(make_req(2023, 5, 0, 0, 0, 0, 0));
        // start year extremes
        pending_dates.push_back(make_req(0, 12, 31, 0, 0, 0, 1));
        pending_dates.push_back(make_req(0, 1, 1, 0, 0, 0, 0));
        pending_dates.push_back(make_req(16383, 7, 4, 0, -9999, 0, 0));
        pending_dates.push_back(make_req(16383, 7, 4, 0, 0, 0, 0));
        // result just outside the year range
        pending_dates.push_back(make_req(9999, 12, 31, 0, 0, 0, 1));
        pending_dates.push_back(make_req(1, 1, 1, 0, 0, 0, -1));
        // offset extremes
        pending_dates.push_back(make_req(1, 1, 1, 0, 0, 0, 4194303));
        pending_dates.push_back(make_req(9999, 12, 31, 0, 0, 0, -4194304));
        pending_dates.push_back(make_req(2000, 2, 29, 0, 16383, 0, 0));
        pending_dates.push_back(make_req(16383, 1, 1, 0, -16384, 131071, 0));
        pending_dates.push_back(make_req(16383, 1, 31, 0, 0, -131072, 0));
        // year below one in between, back in range through days
        pending_dates.push_back(make_req(3, 3, 31, 0, -5, 0, 3000));
        // century leap rules and a leap-day clamp
        pending_dates.push_back(make_req(1900, 2, 28, 0, 0, 0, 1));
        pending_dates.push_back(make_req(2000, 2, 29, 0, 1, 0, 0));

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                req = make_req($urandom_range(0, 16383), $urandom_range(0, 15),
                               $urandom_range(0, 31), $urandom_range(0, 1),
                               $urandom, $urandom, $urandom);
            else
            begin
                if (kind == 1)
                    y = $urandom_range(0, 1) ? $urandom_range(1, 30) : $urandom_range(9970, 9999);
                else
                    y = $urandom_range(1, 9999);
                mo = $urandom_range(1, 12);
                dy = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 31);
                case ($urandom_range(0, 3))
                    0:       yo = $urandom_range(0, 100) - 50;
                    1:       yo = $urandom_range(0, 4000) - 2000;
                    default: yo = 0;
                endcase
                case ($urandom_range(0, 3))
                    0:       mof = $urandom_range(0, 60) - 30;
                    1:       mof = $urandom_range(0, 1200) - 600;
                    default: mof = 0;
                endcase
                case ($urandom_range(0, 5))
                    0:       dof = 0;
                    1, 2:    dof = $urandom_range(0, 80) - 40;
                    3, 4:    dof = $urandom_range(0, 400000) - 200000;
                    default: dof = $urandom_range(0, 8388607) - 4194304;
                endcase
                req = make_req(y, mo, dy, ($urandom_range(0, 19) == 0), yo, mof, dof);
            end
            // sender waits for the pipeline to drain before these
            if (i == 0 || i == 300)
                req.drain = 1'b1;
            pending_dates.push_back(req);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_dates.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_dates.size() > 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (error_count == 0 && expected_dates.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
